>>> hw/rtl/dra_pkg.sv
`timescale 1ns / 1ps

package dra_pkg;

  typedef enum logic [1:0] {
    MODE_TRANSPOSE = 2'd0,
    MODE_ROT90     = 2'd1,
    MODE_ROT180    = 2'd2,
    MODE_ROT270    = 2'd3
  } rot_mode_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 14;
  localparam int SIZE_W     = 13;
  localparam int STRIDE_W   = 14;
  localparam int OFF_W      = 26;
  localparam int BYTE_W     = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;

  localparam logic [CFG_ADDR_W-1:0] REG_ROTATE_MODE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAIR_WIDTH     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STRIDE_PLANE_A = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STRIDE_PLANE_B = 3'd4;

endpackage

>>> hw/rtl/deinterleave_rotate_address_gen.sv
`timescale 1ns / 1ps

// Deinterleave and rotate address generator.
// The input stream carries one interleaved byte pair per request in raster
// order of the source frame. Each pair leaves on the output stream split into
// its plane A and plane B bytes, together with the destination byte offset of
// each within its plane under the mapping chosen by rotate_mode (transpose,
// rotate 90, rotate 180, rotate 270). tlast marks the frame's final pair; the
// row and column counters then start over at zero.
// Throughput is one pair per cycle while the receiver does not stall. A pair
// passes through the input register, which holds the bytes and the operands
// picked from the counters, then the result register, which holds the result
// after the two multiply-adds (one 26 x 14 multiplier per plane).
// A stalled receiver holds the output register; the input register behind it
// still takes one more pair, then in_tready drops until the output drains.
// Reset (rst_n low, synchronous) empties both registers, clears the counters
// and loads the registers with mode transpose, width, height and strides of 1.
// The configuration port writes one register per cycle with cfg_we high and
// should be used only while the pipeline is empty.

module deinterleave_rotate_address_gen
  import dra_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // first_byte[7:0], second_byte[15:8]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // plane_a_byte[7:0], plane_b_byte[15:8], offset_a[41:16], offset_b[67:42], zeros
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // frame_last
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
  localparam logic [SW-1:0] SIZE_TOP = SW'(1) << COORD_BITS;

  // configuration registers
  rot_mode_t             mode_r;
  logic [SIZE_W-1:0]     width_r;
  logic [SIZE_W-1:0]     height_r;
  logic [STRIDE_W-1:0]   stride_a_r;
  logic [STRIDE_W-1:0]   stride_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_TRANSPOSE;
      width_r    <= SIZE_W'(1);
      height_r   <= SIZE_W'(1);
      stride_a_r <= STRIDE_W'(1);
      stride_b_r <= STRIDE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROTATE_MODE:    mode_r     <= rot_mode_t'(cfg_wdata[1:0]);
        REG_PAIR_WIDTH:     width_r    <= cfg_wdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   height_r   <= cfg_wdata[SIZE_W-1:0];
        REG_STRIDE_PLANE_A: stride_a_r <= cfg_wdata;
        REG_STRIDE_PLANE_B: stride_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective size minus one, zero taken as 1 and clamped to 2^COORD_BITS
  function automatic logic [COORD_BITS-1:0] size_m1(input logic [SIZE_W-1:0] v);
    logic [SW-1:0] ve;
    ve = SW'(v);
    if (v == '0) size_m1 = '0;
    else if (ve >= SIZE_TOP) size_m1 = '1;
    else size_m1 = COORD_BITS'(ve - SW'(1));
  endfunction

  logic [COORD_BITS-1:0] wm1, hm1;
  assign wm1 = size_m1(width_r);
  assign hm1 = size_m1(height_r);

  // source position counters
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic                  row_end, frame_end;
  logic                  in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign row_end   = col_r >= wm1;
  assign frame_end = row_end && (row_r >= hm1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (frame_end) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_r + COORD_BITS'(1);
    end else begin
      col_nxt = col_r + COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // operand pick: offset = add + mul * stride
  logic [OFF_W-1:0] rev_row, rev_col;
  logic [OFF_W-1:0] add_nxt, mul_nxt;

  assign rev_row = OFF_W'(hm1) - OFF_W'(row_r);
  assign rev_col = OFF_W'(wm1) - OFF_W'(col_r);

  always_comb begin
    unique case (mode_r)
      MODE_TRANSPOSE: begin add_nxt = OFF_W'(row_r); mul_nxt = OFF_W'(col_r); end
      MODE_ROT90:     begin add_nxt = rev_row;       mul_nxt = OFF_W'(col_r); end
      MODE_ROT180:    begin add_nxt = rev_col;       mul_nxt = rev_row;       end
      MODE_ROT270:    begin add_nxt = OFF_W'(row_r); mul_nxt = rev_col;       end
      default:        begin add_nxt = OFF_W'(row_r); mul_nxt = OFF_W'(col_r); end
    endcase
  end

  // input register
  logic              s1_valid_r;
  logic              s1_adv;
  logic [OFF_W-1:0]  add_r, mul_r;
  logic [BYTE_W-1:0] byte_a_r, byte_b_r;
  logic              last_r;

  assign s1_adv    = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      add_r    <= add_nxt;
      mul_r    <= mul_nxt;
      byte_a_r <= in_tdata[BYTE_W-1:0];
      byte_b_r <= in_tdata[2*BYTE_W-1:BYTE_W];
      last_r   <= frame_end;
    end
  end

  // multiply-add per plane, modulo 2^26
  logic [OFF_W+STRIDE_W-1:0] prod_a, prod_b;
  logic [OFF_W-1:0]          off_a_nxt, off_b_nxt;

  assign prod_a    = mul_r * stride_a_r;
  assign prod_b    = mul_r * stride_b_r;
  assign off_a_nxt = add_r + prod_a[OFF_W-1:0];
  assign off_b_nxt = add_r + prod_b[OFF_W-1:0];

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= {(OUT_DATA_W - 2*BYTE_W - 2*OFF_W)'(0), off_b_nxt, off_a_nxt,
                     byte_b_r, byte_a_r};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // the frame's final pair sends the counters back to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_end) |=> (row_r == '0 && col_r == '0))
    else $error("counters did not wrap after the last pair");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !row_end) |=> (col_r == $past(col_r) + COORD_BITS'(1)
                              && row_r == $past(row_r)))
    else $error("column counter did not step");

  // a held request in the input register is not dropped while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(add_r) && $stable(mul_r)))
    else $error("input register lost a request under stall");

endmodule
